// ===== hdl/routing_network_prefix_table_top_defines.svh =====
// assertion macros for the prefix table
`ifndef ROUTING_NETWORK_PREFIX_TABLE_TOP_DEFINES_SVH
`define ROUTING_NETWORK_PREFIX_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RNPT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rnpt assertion failed");

// next-cycle implication
`define RNPT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rnpt assertion failed");

`else

`define RNPT_ASSERT_IMP(label, clk, rst, ante, cons)
`define RNPT_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/rnpt_pkg.sv =====
`timescale 1ns / 1ps

package rnpt_pkg;

   // action codes
   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_FIND  = 2'd1;
   localparam logic [1:0] ACT_MATCH = 2'd2;

   // status codes
   localparam logic [2:0] ST_ADDED     = 3'd0;
   localparam logic [2:0] ST_PRESENT   = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_FOUND     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] address;
      logic [31:0] mask;
      logic [7:0]  query_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  net_id;
      logic [31:0] entry_prefix;
      logic [31:0] entry_mask;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE
   } ctrl_state_type;

   // which answer the datapath builds
   typedef enum logic [1:0] {
      RES_HIT,
      RES_MISS,
      RES_ADDED
   } res_type;

   typedef struct packed {
      logic    load;
      logic    scan;
      logic    write;
      logic    finish;
      res_type res;
   } cmd_type;

   typedef struct packed {
      logic eval_vld;
      logic hit;
      logic last;
      logic skip;
      logic full;
      logic is_add;
   } stat_type;

   // classful mask from the leading bits of a prefix
   function automatic logic [31:0] classful_mask(input logic [31:0] a);
      logic [31:0] m;
      if (!a[31]) begin
         m = 32'hFF00_0000;
      end else if (!a[30]) begin
         m = 32'hFFFF_0000;
      end else if (!a[29]) begin
         m = 32'hFFFF_FF00;
      end else begin
         m = 32'hFFFF_FFFF;
      end
      return m;
   endfunction

   // lowest set bit, one-hot; a longer mask has a smaller lowest bit
   function automatic logic [31:0] low_bit(input logic [31:0] m);
      return m & (~m + 32'd1);
   endfunction

endpackage

// ===== hdl/rnpt_ctrl.sv =====
`timescale 1ns / 1ps

module rnpt_ctrl import rnpt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.res    = RES_MISS;
      busy       = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.skip) begin
               if (stat.is_add) begin
                  state_in = S_WRITE;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end else if (stat.eval_vld && stat.hit) begin
               cmd.finish = 1'b1;
               cmd.res    = RES_HIT;
               state_in   = S_IDLE;
            end else if (stat.eval_vld && stat.last) begin
               if (stat.is_add && !stat.full) begin
                  state_in = S_WRITE;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         S_WRITE: begin
            cmd.write  = 1'b1;
            cmd.finish = 1'b1;
            cmd.res    = RES_ADDED;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/rnpt_dpath.sv =====
`timescale 1ns / 1ps

module rnpt_dpath import rnpt_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_item,
   input  logic       csr_write,
   input  logic [7:0] csr_data,
   input  cmd_type    cmd,
   output stat_type   stat,
   output logic       rsp_strobe,
   output rsp_type    rsp_item
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // latched item
   logic [1:0]  act_ff;
   logic [31:0] addr_ff;
   logic [31:0] mask_ff;
   logic [7:0]  qid_ff;
   logic [31:0] iflsb_ff;

   logic [7:0]       first_id_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] eval_idx_ff;
   logic             eval_vld_ff;
   logic [63:0]      rd_data_ff;
   logic [63:0]      mem [DEPTH];
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_strobe_ff;

   logic        issue;
   logic [31:0] ent_p, ent_m, sel_m;
   logic [7:0]  eval_id;
   logic        match_ok;
   logic        hit;

   // item latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_item.action;
         addr_ff  <= req_item.address;
         mask_ff  <= req_item.mask;
         qid_ff   <= req_item.query_id;
         iflsb_ff <= low_bit(req_item.mask);
      end
   end

   // scan pointer and entry count
   assign issue    = cmd.scan && (idx_ff < count_ff);
   assign idx_in   = cmd.load ? '0 : (issue ? CNT_W'(idx_ff + 1'b1) : idx_ff);
   assign count_in = cmd.write ? CNT_W'(count_ff + 1'b1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         count_ff      <= '0;
         eval_vld_ff   <= 1'b0;
         first_id_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         eval_vld_ff   <= issue;
         rsp_strobe_ff <= cmd.finish;
         if (csr_write) begin
            first_id_ff <= csr_data;
         end
      end
   end

   // table memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[count_ff[IDX_W-1:0]] <= {addr_ff, mask_ff};
      end
      if (issue) begin
         rd_data_ff <= mem[idx_ff[IDX_W-1:0]];
      end
      eval_idx_ff <= idx_ff;
   end

   // entry test
   assign ent_p   = rd_data_ff[63:32];
   assign ent_m   = rd_data_ff[31:0];
   assign sel_m   = (ent_m == '0) ? classful_mask(ent_p) : ent_m;
   assign eval_id = first_id_ff + 8'(eval_idx_ff);
   assign match_ok = (ent_p == '0) ||
                     ((((ent_p ^ addr_ff) & sel_m) == '0) && (iflsb_ff != '0) &&
                      (low_bit(sel_m) >= iflsb_ff));

   always_comb begin
      case (act_ff)
         ACT_ADD:   hit = (ent_p == addr_ff) && (ent_m == mask_ff);
         ACT_FIND:  hit = (eval_id == qid_ff);
         ACT_MATCH: hit = match_ok;
         default:   hit = 1'b0;
      endcase
   end

   assign stat.eval_vld = eval_vld_ff;
   assign stat.hit      = hit;
   assign stat.last     = (CNT_W'(eval_idx_ff + 1'b1) == count_ff);
   assign stat.skip     = (count_ff == '0) || (act_ff == ACT_MATCH && addr_ff == '0) ||
                          (act_ff != ACT_ADD && act_ff != ACT_FIND && act_ff != ACT_MATCH);
   assign stat.full     = (count_ff == CNT_W'(DEPTH));
   assign stat.is_add   = (act_ff == ACT_ADD);

   // result build
   always_comb begin
      rsp_in = '0;
      unique case (cmd.res)
         RES_HIT: begin
            rsp_in.status = (act_ff == ACT_ADD) ? ST_PRESENT : ST_FOUND;
            rsp_in.net_id = eval_id;
            if (act_ff == ACT_FIND) begin
               rsp_in.entry_prefix = ent_p;
               rsp_in.entry_mask   = ent_m;
            end
         end
         RES_ADDED: begin
            rsp_in.status = ST_ADDED;
            rsp_in.net_id = first_id_ff + 8'(count_ff);
         end
         RES_MISS: begin
            rsp_in.status = (act_ff == ACT_ADD) ? ST_FULL : ST_NOT_FOUND;
         end
         default: begin
            rsp_in.status = ST_NOT_FOUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== hdl/routing_network_prefix_table_top.sv =====
`timescale 1ns / 1ps
// channel   ports                               transfer
// request   start, busy, req_item               start high while busy low
// result    rsp_strobe, rsp_item                one-cycle strobe, never held off
// config    csr_valid, csr_ready, csr_data      valid and ready both high
//
// an item is accepted, then its stored entries are read and tested in turn until a
// hit or the last one (at most DEPTH), an add that appends then writes its entry,
// and the result strobe is registered; the single read port of the table memory scans one entry per cycle.
// reset clears the entry count, first_id and control; the table needs no clear.
// busy is high while an item is at work; the result cycle does not stall intake.

`include "routing_network_prefix_table_top_defines.svh"

module routing_network_prefix_table_top import rnpt_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_item,
   output logic       rsp_strobe,
   output rsp_type    rsp_item,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   // configuration taken only between items
   assign csr_ready = !busy;

   rnpt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   rnpt_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // accepted item keeps the block busy next cycle
   `RNPT_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   // a result appears only after the controller went back to idle
   `RNPT_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_strobe, !busy)
   // full and not-found carry no identifier
   `RNPT_ASSERT_IMP(a_miss_id, clock, reset,
      rsp_strobe && (rsp_item.status == ST_FULL || rsp_item.status == ST_NOT_FOUND),
      rsp_item.net_id == 8'd0)

endmodule
